FILE: design/image_download_receiver_unit_macros.svh
// Assertion macros used by the checker of the image download receiver.
`ifndef IMAGE_DOWNLOAD_RECEIVER_UNIT_MACROS_SVH
`define IMAGE_DOWNLOAD_RECEIVER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IDRX_ASSERT_SAME(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("idrx assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define IDRX_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("idrx assertion failed in the following cycle");

`endif

FILE: design/idrx_pkg.sv
// Types, codes and helper functions of the image download receiver.
package idrx_pkg;

   localparam logic [1:0] CMD_BYTE       = 2'd0;
   localparam logic [1:0] CMD_TICK       = 2'd1;
   localparam logic [1:0] CMD_FLASH_FAIL = 2'd2;

   localparam logic [1:0] KIND_HOST  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_ERASE = 2'd2;

   localparam logic [7:0] BYTE_REQUEST = 8'hA1;
   localparam logic [7:0] BYTE_ACK     = 8'hA2;
   localparam logic [7:0] BYTE_READY   = 8'hA3;
   localparam logic [7:0] BYTE_ERASED  = 8'hA4;
   localparam logic [7:0] BYTE_PASS    = 8'hA5;
   localparam logic [7:0] BYTE_FAIL    = 8'hA7;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [1:0] REG_MAX_IMAGE     = 2'd0;
   localparam logic [1:0] REG_REPEATS       = 2'd1;
   localparam logic [1:0] REG_READY_TIMEOUT = 2'd2;
   localparam logic [1:0] REG_IDLE_TIMEOUT  = 2'd3;

   localparam logic [24:0] RST_MAX_IMAGE     = 25'd524288;
   localparam logic [5:0]  RST_REPEATS       = 6'd32;
   localparam logic [9:0]  RST_READY_TIMEOUT = 10'd200;
   localparam logic [11:0] RST_IDLE_TIMEOUT  = 12'd1000;

   localparam int CSR_DATA_BITS  = 25;
   localparam int CSR_INDEX_BITS = 2;

   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_BITS = 2;

   typedef enum logic [1:0] {
      PH_HANDSHAKE  = 2'd0,
      PH_WAIT_READY = 2'd1,
      PH_TRANSFER   = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      OP_ACK   = 3'd0,
      OP_ERASE = 3'd1,
      OP_WRITE = 3'd2,
      OP_PASS  = 3'd3,
      OP_FAIL  = 3'd4
   } job_op_type;

   typedef struct packed {
      job_op_type  op;
      logic [23:0] offset;
      logic [7:0]  data;
      logic [24:0] count;
   } job_type;

   typedef struct packed {
      logic [24:0] max_image;
      logic [5:0]  repeats;
      logic [9:0]  ready_timeout;
      logic [11:0] idle_timeout;
   } cfg_type;

   function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

FILE: design/image_download_receiver_unit.sv
// Top level of the image download receiver: settings registers, front end, job queue, back end.
//
//   Channel   Direction  Handshake          Payload
//   req_      in         req_valid/ready    command, rx_byte
//   rsp_      out        rsp_valid/ready    kind, tx_byte, write_offset, write_data, ...
//   csr_      in         csr_we             csr_index, csr_wdata
//
// One request transaction is taken per cycle while the four-entry job queue has room.
// A request's first result passes the job queue and then the output register of the back end,
// which issues one result per cycle when not stalled, two for an erase and three for a failure.
// Reset is synchronous and restores the handshake phase and the default settings.
// A stalled result channel fills the queue, after which req_ready falls.
module image_download_receiver_unit #(
   parameter int COUNT_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_command,
   input  logic [7:0]                           req_rx_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_kind,
   output logic [7:0]                           rsp_tx_byte,
   output logic [23:0]                          rsp_write_offset,
   output logic [7:0]                           rsp_write_data,
   output logic [24:0]                          rsp_byte_count,
   output logic                                 rsp_last,
   input  logic                                 csr_we,
   input  logic [idrx_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [idrx_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   idrx_pkg::cfg_type cfg_ff, cfg_in;
   idrx_pkg::job_type push_job;
   idrx_pkg::job_type head_job;
   logic              push;
   logic              full;
   logic              pop;
   logic              head_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            idrx_pkg::REG_MAX_IMAGE:     cfg_in.max_image     = csr_wdata;
            idrx_pkg::REG_REPEATS:       cfg_in.repeats       = csr_wdata[5:0];
            idrx_pkg::REG_READY_TIMEOUT: cfg_in.ready_timeout = csr_wdata[9:0];
            idrx_pkg::REG_IDLE_TIMEOUT:  cfg_in.idle_timeout  = csr_wdata[11:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_image     <= idrx_pkg::RST_MAX_IMAGE;
         cfg_ff.repeats       <= idrx_pkg::RST_REPEATS;
         cfg_ff.ready_timeout <= idrx_pkg::RST_READY_TIMEOUT;
         cfg_ff.idle_timeout  <= idrx_pkg::RST_IDLE_TIMEOUT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   idrx_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_command (req_command),
      .in_rx_byte (req_rx_byte),
      .job_full   (full),
      .job_push   (push),
      .job        (push_job)
   );

   idrx_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   idrx_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_job         (head_job),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_write_offset (rsp_write_offset),
      .rsp_write_data   (rsp_write_data),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_last         (rsp_last)
   );

endmodule

FILE: design/idrx_fifo.sv
// Short job queue between the classifying front end and the result back end.
module idrx_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  idrx_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output idrx_pkg::job_type head_job
);

   idrx_pkg::job_type                   slot_ff [idrx_pkg::FIFO_DEPTH];
   logic [idrx_pkg::FIFO_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [idrx_pkg::FIFO_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [idrx_pkg::FIFO_PTR_BITS:0]    fill_ff, fill_in;

   assign full       = (fill_ff == (idrx_pkg::FIFO_PTR_BITS+1)'(idrx_pkg::FIFO_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: design/idrx_front.sv
// Front end: accepts transactions, runs the protocol state and queues result jobs.
module idrx_front #(
   parameter int COUNT_BITS = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  idrx_pkg::cfg_type cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [1:0]        in_command,
   input  logic [7:0]        in_rx_byte,
   input  logic              job_full,
   output logic              job_push,
   output idrx_pkg::job_type job
);

   localparam int CW = COUNT_BITS + 1;
   localparam int WW = (CW > 25) ? CW : 25;

   idrx_pkg::phase_type phase_ff, phase_in;
   logic [5:0]    hs_count_ff, hs_count_in;
   logic [CW-1:0] rcv_count_ff, rcv_count_in;
   logic [15:0]   crc_ff, crc_in;
   logic [11:0]   tick_ff, tick_in;
   logic          error_ff, error_in;

   logic          accept;
   logic [11:0]   tick_inc;
   logic          ready_hit;
   logic          idle_hit;
   logic [6:0]    hs_next;
   logic          hs_done;
   logic [CW-1:0] count_next;
   logic [WW-1:0] count_wide;
   logic [WW-1:0] cur_wide;
   logic          err_byte;
   logic          is_byte;
   logic          is_tick;

   assign in_ready   = !job_full;
   assign accept     = in_valid && !job_full;
   assign is_byte    = (in_command == idrx_pkg::CMD_BYTE);
   assign is_tick    = (in_command == idrx_pkg::CMD_TICK);
   assign tick_inc   = tick_ff + 12'd1;
   assign ready_hit  = (tick_inc >= {2'b00, cfg.ready_timeout});
   assign idle_hit   = (tick_inc >= cfg.idle_timeout);
   assign hs_next    = {1'b0, hs_count_ff} + 7'd1;
   assign hs_done    = (hs_next >= {1'b0, cfg.repeats});
   assign count_next = rcv_count_ff[COUNT_BITS] ? rcv_count_ff : rcv_count_ff + CW'(1);
   assign count_wide = WW'(count_next);
   assign cur_wide   = WW'(rcv_count_ff);
   assign err_byte   = error_ff || (count_wide > WW'(cfg.max_image));

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            idrx_pkg::PH_WAIT_READY: begin
               if (is_byte && in_rx_byte == idrx_pkg::BYTE_READY) begin
                  phase_in = idrx_pkg::PH_TRANSFER;
               end
            end
            idrx_pkg::PH_TRANSFER: begin
               if (is_tick && idle_hit) begin
                  phase_in = idrx_pkg::PH_HANDSHAKE;
               end
            end
            default: begin
               if (is_byte && in_rx_byte == idrx_pkg::BYTE_REQUEST && hs_done) begin
                  phase_in = idrx_pkg::PH_WAIT_READY;
               end else begin
                  phase_in = idrx_pkg::PH_HANDSHAKE;
               end
            end
         endcase
      end
   end

   always_comb begin
      hs_count_in  = hs_count_ff;
      rcv_count_in = rcv_count_ff;
      crc_in       = crc_ff;
      tick_in      = tick_ff;
      error_in     = error_ff;
      job_push     = 1'b0;
      job.op       = idrx_pkg::OP_ACK;
      job.offset   = '0;
      job.data     = '0;
      job.count    = cur_wide[24:0];
      if (accept) begin
         unique case (phase_ff)
            idrx_pkg::PH_WAIT_READY: begin
               if (is_byte) begin
                  tick_in = '0;
                  if (in_rx_byte == idrx_pkg::BYTE_READY) begin
                     rcv_count_in = '0;
                     crc_in       = idrx_pkg::CRC_INIT;
                     error_in     = 1'b0;
                     job_push     = 1'b1;
                     job.op       = idrx_pkg::OP_ERASE;
                     job.count    = '0;
                  end
               end else if (is_tick) begin
                  tick_in = ready_hit ? '0 : tick_inc;
               end
            end
            idrx_pkg::PH_TRANSFER: begin
               if (is_byte) begin
                  tick_in      = '0;
                  crc_in       = idrx_pkg::crc16_fold(crc_ff, in_rx_byte);
                  rcv_count_in = count_next;
                  error_in     = err_byte;
                  job_push     = !err_byte;
                  job.op       = idrx_pkg::OP_WRITE;
                  job.offset   = cur_wide[23:0];
                  job.data     = in_rx_byte;
                  job.count    = count_wide[24:0];
               end else if (is_tick) begin
                  if (idle_hit) begin
                     tick_in     = '0;
                     hs_count_in = '0;
                     job_push    = 1'b1;
                     if (!error_ff && rcv_count_ff != '0 && crc_ff == 16'h0000) begin
                        job.op = idrx_pkg::OP_PASS;
                     end else begin
                        job.op = idrx_pkg::OP_FAIL;
                     end
                  end else begin
                     tick_in = tick_inc;
                  end
               end else if (in_command == idrx_pkg::CMD_FLASH_FAIL) begin
                  error_in = 1'b1;
               end
            end
            default: begin
               if (is_byte) begin
                  if (in_rx_byte == idrx_pkg::BYTE_REQUEST) begin
                     if (hs_done) begin
                        hs_count_in = '0;
                        tick_in     = '0;
                        job_push    = 1'b1;
                        job.op      = idrx_pkg::OP_ACK;
                     end else begin
                        hs_count_in = hs_next[5:0];
                     end
                  end else begin
                     hs_count_in = '0;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= idrx_pkg::PH_HANDSHAKE;
         hs_count_ff  <= '0;
         rcv_count_ff <= '0;
         crc_ff       <= idrx_pkg::CRC_INIT;
         tick_ff      <= '0;
         error_ff     <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         hs_count_ff  <= hs_count_in;
         rcv_count_ff <= rcv_count_in;
         crc_ff       <= crc_in;
         tick_ff      <= tick_in;
         error_ff     <= error_in;
      end
   end

endmodule

FILE: design/idrx_back.sv
// Back end: expands each queued job into its result transactions through an output register.
module idrx_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  idrx_pkg::job_type head_job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_kind,
   output logic [7:0]        rsp_tx_byte,
   output logic [23:0]       rsp_write_offset,
   output logic [7:0]        rsp_write_data,
   output logic [24:0]       rsp_byte_count,
   output logic              rsp_last
);

   logic [1:0]  idx_ff, idx_in;
   logic        rsp_valid_ff;
   logic [1:0]  rsp_kind_ff;
   logic [7:0]  rsp_tx_byte_ff;
   logic [23:0] rsp_write_offset_ff;
   logic [7:0]  rsp_write_data_ff;
   logic [24:0] rsp_byte_count_ff;
   logic        rsp_last_ff;

   logic        load;
   logic        emit;
   logic [1:0]  last_idx;
   logic        is_last;
   logic [1:0]  kind_in;
   logic [7:0]  tx_in;
   logic [23:0] offset_in;
   logic [7:0]  data_in;

   assign load    = !rsp_valid_ff || rsp_ready;
   assign emit    = head_valid && load;
   assign is_last = (idx_ff == last_idx);
   assign pop     = emit && is_last;
   assign idx_in  = emit ? (is_last ? 2'd0 : idx_ff + 2'd1) : idx_ff;

   always_comb begin
      last_idx  = 2'd0;
      kind_in   = idrx_pkg::KIND_HOST;
      tx_in     = '0;
      offset_in = '0;
      data_in   = '0;
      unique case (head_job.op)
         idrx_pkg::OP_ACK: begin
            tx_in = idrx_pkg::BYTE_ACK;
         end
         idrx_pkg::OP_ERASE: begin
            last_idx = 2'd1;
            if (idx_ff == 2'd0) begin
               kind_in = idrx_pkg::KIND_ERASE;
            end else begin
               tx_in = idrx_pkg::BYTE_ERASED;
            end
         end
         idrx_pkg::OP_WRITE: begin
            kind_in   = idrx_pkg::KIND_WRITE;
            offset_in = head_job.offset;
            data_in   = head_job.data;
         end
         idrx_pkg::OP_PASS: begin
            tx_in = idrx_pkg::BYTE_PASS;
         end
         default: begin
            last_idx = 2'd2;
            tx_in    = idrx_pkg::BYTE_FAIL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (load) begin
            rsp_valid_ff <= emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff         <= kind_in;
         rsp_tx_byte_ff      <= tx_in;
         rsp_write_offset_ff <= offset_in;
         rsp_write_data_ff   <= data_in;
         rsp_byte_count_ff   <= head_job.count;
         rsp_last_ff         <= is_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_tx_byte      = rsp_tx_byte_ff;
   assign rsp_write_offset = rsp_write_offset_ff;
   assign rsp_write_data   = rsp_write_data_ff;
   assign rsp_byte_count   = rsp_byte_count_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

FILE: design/idrx_checker.sv
// Port-level checker of the image download receiver and its bind to the top level.
`include "image_download_receiver_unit_macros.svh"

module idrx_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_last
);

   `IDRX_ASSERT_SAME(a_erase_not_last, clock, reset, rsp_valid && rsp_kind == idrx_pkg::KIND_ERASE, !rsp_last)

   `IDRX_ASSERT_NEXT(a_erase_then_ack, clock, reset, rsp_valid && rsp_ready && rsp_kind == idrx_pkg::KIND_ERASE, rsp_valid && rsp_kind == idrx_pkg::KIND_HOST && rsp_tx_byte == idrx_pkg::BYTE_ERASED)

   `IDRX_ASSERT_SAME(a_no_code_off_host, clock, reset, rsp_valid && rsp_kind != idrx_pkg::KIND_HOST, rsp_tx_byte == 8'h00)

   `IDRX_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_tx_byte) && $stable(rsp_last))

endmodule

bind image_download_receiver_unit idrx_checker u_idrx_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_kind    (rsp_kind),
   .rsp_tx_byte (rsp_tx_byte),
   .rsp_last    (rsp_last)
);

FILE: tb/tb_image_download_receiver_unit.sv
// Self-checking testbench of the image download receiver, with its own model of the protocol.
module tb_image_download_receiver_unit;

   localparam int LIMIT_CYCLES = 1000000;
   localparam int SHOW_MISMATCHES = 10;
   localparam logic [24:0] COUNT_CAP = 25'h1000000;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  tx_byte;
      logic [23:0] write_offset;
      logic [7:0]  write_data;
      logic [24:0] byte_count;
      logic        last;
   } download_result_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic [1:0]                          req_command = idrx_pkg::CMD_BYTE;
   logic [7:0]                          req_rx_byte = 8'h00;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [1:0]                          rsp_kind;
   logic [7:0]                          rsp_tx_byte;
   logic [23:0]                         rsp_write_offset;
   logic [7:0]                          rsp_write_data;
   logic [24:0]                         rsp_byte_count;
   logic                                rsp_last;
   logic                                csr_we = 1'b0;
   logic [idrx_pkg::CSR_INDEX_BITS-1:0] csr_index = idrx_pkg::REG_MAX_IMAGE;
   logic [idrx_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int items_sent = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   idrx_pkg::cfg_type   dl_cfg;
   idrx_pkg::phase_type dl_phase;
   logic [5:0]          hs_count;
   logic [24:0]         rcv_count;
   logic [15:0]         crc_acc;
   logic [11:0]         tick_count;
   logic                err_flag;

   download_result_type pending_results[$];
   download_result_type observed_result;
   download_result_type wanted_result;

   image_download_receiver_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_write_offset (rsp_write_offset),
      .rsp_write_data   (rsp_write_data),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_last         (rsp_last),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) @(posedge clock);
      $display("image_download_receiver_unit verification failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         observed_result = {rsp_kind, rsp_tx_byte, rsp_write_offset, rsp_write_data,
                            rsp_byte_count, rsp_last};
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= SHOW_MISMATCHES)
               $display("cycle %0d: unexpected kind %0d tx %h off %h data %h count %0d last %b",
                        cycle_count, rsp_kind, rsp_tx_byte, rsp_write_offset, rsp_write_data,
                        rsp_byte_count, rsp_last);
         end else begin
            wanted_result = pending_results.pop_front();
            if (observed_result !== wanted_result) begin
               mismatch_count++;
               if (mismatch_count <= SHOW_MISMATCHES) begin
                  $display("cycle %0d: expected kind %0d tx %h off %h data %h count %0d last %b",
                           cycle_count, wanted_result.kind, wanted_result.tx_byte,
                           wanted_result.write_offset, wanted_result.write_data,
                           wanted_result.byte_count, wanted_result.last);
                  $display("   got kind %0d tx %h off %h data %h count %0d last %b",
                           rsp_kind, rsp_tx_byte, rsp_write_offset, rsp_write_data,
                           rsp_byte_count, rsp_last);
               end
            end
         end
      end
   end

   // Reflected CRC-16 update, one data bit at a time against the low bit of the register.
   function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] r;
      r = crc;
      for (int k = 0; k < 8; k++) begin
         if (r[0] ^ b[k])
            r = {1'b0, r[15:1]} ^ 16'hA001;
         else
            r = {1'b0, r[15:1]};
      end
      return r;
   endfunction

   function automatic download_result_type download_result(input logic [1:0] kind,
                                                           input logic [7:0] tx,
                                                           input logic [23:0] offset,
                                                           input logic [7:0] data);
      return '{kind, tx, offset, data, rcv_count, 1'b0};
   endfunction

   task automatic predict_download_step(input logic [1:0] cmd, input logic [7:0] b);
      download_result_type produced[$];
      logic [23:0] off;
      int k;
      case (dl_phase)
         idrx_pkg::PH_WAIT_READY: begin
            if (cmd == idrx_pkg::CMD_BYTE) begin
               tick_count = '0;
               if (b == idrx_pkg::BYTE_READY) begin
                  rcv_count = '0;
                  crc_acc = idrx_pkg::CRC_INIT;
                  err_flag = 1'b0;
                  dl_phase = idrx_pkg::PH_TRANSFER;
                  produced.push_back(download_result(idrx_pkg::KIND_ERASE, 8'h00, 24'h0,
                                                     8'h00));
                  produced.push_back(download_result(idrx_pkg::KIND_HOST,
                                                     idrx_pkg::BYTE_ERASED, 24'h0, 8'h00));
               end
            end else if (cmd == idrx_pkg::CMD_TICK) begin
               tick_count = tick_count + 12'd1;
               if (tick_count >= {2'b00, dl_cfg.ready_timeout})
                  tick_count = '0;
            end
         end
         idrx_pkg::PH_TRANSFER: begin
            if (cmd == idrx_pkg::CMD_BYTE) begin
               off = rcv_count[23:0];
               tick_count = '0;
               crc_acc = modbus_crc_step(crc_acc, b);
               if (rcv_count < COUNT_CAP)
                  rcv_count = rcv_count + 25'd1;
               if (rcv_count > dl_cfg.max_image)
                  err_flag = 1'b1;
               if (!err_flag)
                  produced.push_back(download_result(idrx_pkg::KIND_WRITE, 8'h00, off, b));
            end else if (cmd == idrx_pkg::CMD_TICK) begin
               tick_count = tick_count + 12'd1;
               if (tick_count >= dl_cfg.idle_timeout) begin
                  tick_count = '0;
                  if (!err_flag && rcv_count != '0 && crc_acc == 16'h0000) begin
                     produced.push_back(download_result(idrx_pkg::KIND_HOST,
                                                        idrx_pkg::BYTE_PASS, 24'h0, 8'h00));
                  end else begin
                     for (k = 0; k < 3; k++)
                        produced.push_back(download_result(idrx_pkg::KIND_HOST,
                                                           idrx_pkg::BYTE_FAIL, 24'h0, 8'h00));
                  end
                  dl_phase = idrx_pkg::PH_HANDSHAKE;
                  hs_count = '0;
               end
            end else if (cmd == idrx_pkg::CMD_FLASH_FAIL) begin
               err_flag = 1'b1;
            end
         end
         default: begin
            dl_phase = idrx_pkg::PH_HANDSHAKE;
            if (cmd == idrx_pkg::CMD_BYTE) begin
               if (b == idrx_pkg::BYTE_REQUEST) begin
                  if (int'(hs_count) + 1 >= int'(dl_cfg.repeats)) begin
                     hs_count = '0;
                     tick_count = '0;
                     dl_phase = idrx_pkg::PH_WAIT_READY;
                     produced.push_back(download_result(idrx_pkg::KIND_HOST,
                                                        idrx_pkg::BYTE_ACK, 24'h0, 8'h00));
                  end else begin
                     hs_count = hs_count + 6'd1;
                  end
               end else begin
                  hs_count = '0;
               end
            end
         end
      endcase
      if (produced.size() > 0)
         produced[produced.size() - 1].last = 1'b1;
      foreach (produced[i])
         pending_results.push_back(produced[i]);
   endtask

   task automatic send_item(input logic [1:0] cmd, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      predict_download_step(cmd, b);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(idrx_pkg::CMD_BYTE, b);
   endtask

   task automatic send_tick();
      send_item(idrx_pkg::CMD_TICK, 8'($urandom));
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_config(input logic [24:0] max_image, input logic [5:0] repeats,
                             input logic [9:0] ready_timeout, input logic [11:0] idle_timeout);
      settle_block();
      csr_we <= 1'b1;
      csr_index <= idrx_pkg::REG_MAX_IMAGE;
      csr_wdata <= max_image;
      @(posedge clock);
      csr_index <= idrx_pkg::REG_REPEATS;
      csr_wdata <= 25'(repeats);
      @(posedge clock);
      csr_index <= idrx_pkg::REG_READY_TIMEOUT;
      csr_wdata <= 25'(ready_timeout);
      @(posedge clock);
      csr_index <= idrx_pkg::REG_IDLE_TIMEOUT;
      csr_wdata <= 25'(idle_timeout);
      @(posedge clock);
      csr_we <= 1'b0;
      dl_cfg = '{max_image, repeats, ready_timeout, idle_timeout};
   endtask

   // A complete transfer under the reset settings, ended early by shortening the idle timeout.
   task automatic test_reset_defaults();
      repeat (31) send_byte(idrx_pkg::BYTE_REQUEST);
      send_byte(8'h00);
      repeat (32) send_byte(idrx_pkg::BYTE_REQUEST);
      send_byte(idrx_pkg::BYTE_READY);
      send_byte(8'h12);
      send_byte(8'h34);
      send_item(idrx_pkg::CMD_FLASH_FAIL, 8'h00);
      send_byte(8'h56);
      set_config(idrx_pkg::RST_MAX_IMAGE, idrx_pkg::RST_REPEATS, idrx_pkg::RST_READY_TIMEOUT,
                 12'd2);
      repeat (2) send_tick();
   endtask

   task automatic test_special_cases();
      set_config(25'd3, 6'd2, 10'd2, 12'd2);
      send_item(CMD_UNUSED, 8'hFF);
      send_tick();
      send_item(idrx_pkg::CMD_FLASH_FAIL, 8'hFF);
      send_byte(idrx_pkg::BYTE_REQUEST);
      send_byte(8'h00);
      send_byte(idrx_pkg::BYTE_REQUEST);
      send_byte(idrx_pkg::BYTE_REQUEST);
      send_item(idrx_pkg::CMD_FLASH_FAIL, 8'h00);
      send_item(CMD_UNUSED, 8'h00);
      repeat (3) send_tick();
      send_byte(8'h55);
      send_byte(idrx_pkg::BYTE_READY);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'h01);
      repeat (2) send_tick();
   endtask

   task automatic test_zero_thresholds();
      logic [15:0] img_crc;
      set_config(25'd16, 6'd0, 10'd0, 12'd0);
      send_byte(idrx_pkg::BYTE_REQUEST);
      send_tick();
      send_byte(idrx_pkg::BYTE_READY);
      img_crc = modbus_crc_step(modbus_crc_step(idrx_pkg::CRC_INIT, 8'h01), 8'h02);
      send_byte(8'h01);
      send_byte(8'h02);
      send_byte(img_crc[7:0]);
      send_byte(img_crc[15:8]);
      send_tick();
      send_byte(idrx_pkg::BYTE_REQUEST);
      send_byte(idrx_pkg::BYTE_READY);
      send_byte(8'hAA);
      send_item(idrx_pkg::CMD_FLASH_FAIL, 8'h00);
      send_tick();
      set_config(25'd0, 6'd1, 10'd0, 12'd0);
      send_byte(idrx_pkg::BYTE_REQUEST);
      send_byte(idrx_pkg::BYTE_READY);
      send_byte(8'h5A);
      send_tick();
   endtask

   // Largest repeat and timeout settings; idle timeout then lowered below the ticks counted.
   task automatic test_register_extremes();
      logic [15:0] img_crc;
      logic [7:0] b;
      set_config(COUNT_CAP, 6'd63, 10'd1023, 12'd4095);
      repeat (63) send_byte(idrx_pkg::BYTE_REQUEST);
      repeat (10) send_tick();
      send_byte(idrx_pkg::BYTE_READY);
      img_crc = idrx_pkg::CRC_INIT;
      repeat (4) begin
         b = 8'($urandom);
         send_byte(b);
         img_crc = modbus_crc_step(img_crc, b);
      end
      send_byte(img_crc[7:0]);
      send_byte(img_crc[15:8]);
      repeat (10) send_tick();
      set_config(COUNT_CAP, 6'd63, 10'd1023, 12'd1);
      send_tick();
   endtask

   task automatic randomize_config();
      logic [24:0] lim;
      int sel;
      sel = $urandom_range(9);
      if (sel < 6)
         lim = 25'($urandom_range(18, 40));
      else if (sel == 6)
         lim = 25'($urandom_range(0, 3));
      else if (sel == 7)
         lim = COUNT_CAP;
      else if (sel == 8)
         lim = 25'h1FFFFFF;
      else
         lim = 25'($urandom);
      set_config(lim, ($urandom_range(19) == 0) ? 6'd63 : 6'($urandom_range(0, 5)),
                 10'($urandom_range(0, 6)), 12'($urandom_range(0, 6)));
   endtask

   task automatic send_noise();
      repeat ($urandom_range(3, 10)) send_item(2'($urandom_range(0, 3)), 8'($urandom));
   endtask

   // One download from handshake to final reply, occasionally interrupted.
   task automatic run_download_session();
      int break_at;
      int n;
      int r;
      int i;
      int len;
      bit good;
      logic [7:0] b;
      logic [15:0] img_crc;
      break_at = ($urandom_range(4) == 0) ? int'($urandom_range(0, dl_cfg.repeats)) : -1;
      n = 0;
      while (dl_phase == idrx_pkg::PH_HANDSHAKE) begin
         if (n == break_at) begin
            r = $urandom_range(2);
            b = 8'($urandom);
            if (b == idrx_pkg::BYTE_REQUEST)
               b = ~b;
            if (r == 0)
               send_byte(b);
            else if (r == 1)
               send_tick();
            else
               send_item(($urandom_range(1) == 0) ? idrx_pkg::CMD_FLASH_FAIL : CMD_UNUSED, b);
         end else begin
            send_byte(idrx_pkg::BYTE_REQUEST);
         end
         n++;
      end
      while (dl_phase == idrx_pkg::PH_WAIT_READY) begin
         r = $urandom_range(99);
         b = 8'($urandom);
         if (b == idrx_pkg::BYTE_READY)
            b = 8'h00;
         if (r < 55)
            send_byte(idrx_pkg::BYTE_READY);
         else if (r < 85)
            send_tick();
         else if (r < 95)
            send_byte(b);
         else
            send_item(($urandom_range(1) == 0) ? idrx_pkg::CMD_FLASH_FAIL : CMD_UNUSED, b);
      end
      if (dl_phase == idrx_pkg::PH_TRANSFER) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 8);
         good = ($urandom_range(3) != 0);
         img_crc = idrx_pkg::CRC_INIT;
         for (i = 0; i < len; i++) begin
            b = 8'($urandom);
            send_byte(b);
            img_crc = modbus_crc_step(img_crc, b);
            r = $urandom_range(19);
            if (r == 0 && int'(tick_count) + 1 < int'(dl_cfg.idle_timeout))
               send_tick();
            else if (r == 1)
               send_item(idrx_pkg::CMD_FLASH_FAIL, 8'($urandom));
         end
         if (good) begin
            send_byte(img_crc[7:0]);
            send_byte(img_crc[15:8]);
         end
         while (dl_phase == idrx_pkg::PH_TRANSFER) send_tick();
      end
   endtask

   task automatic run_random_phase(input int idle_pct, input int stall_pct, input int budget);
      int start;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      start = items_sent;
      while (items_sent - start < budget) begin
         if ($urandom_range(3) == 0)
            randomize_config();
         if ($urandom_range(9) == 0)
            send_noise();
         else
            run_download_session();
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(0, 0, 50);
      run_random_phase(78, 0, 50);
      run_random_phase(0, 78, 50);
      run_random_phase(25, 25, 50);
   endtask

   initial begin
      dl_cfg = '{idrx_pkg::RST_MAX_IMAGE, idrx_pkg::RST_REPEATS, idrx_pkg::RST_READY_TIMEOUT,
                 idrx_pkg::RST_IDLE_TIMEOUT};
      dl_phase = idrx_pkg::PH_HANDSHAKE;
      hs_count = '0;
      rcv_count = '0;
      crc_acc = idrx_pkg::CRC_INIT;
      tick_count = '0;
      err_flag = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_special_cases();
      test_zero_thresholds();
      test_register_extremes();
      test_random_traffic();
      settle_block();
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("image_download_receiver_unit verification clean");
      else
         $display("image_download_receiver_unit verification failed");
      $finish;
   end

endmodule
